/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the receive ring RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is high.
`define FRX_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Implication form: the consequent must hold whenever the antecedent does.
`define FRX_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/core/frx_pkg.sv */
// ----------------------------------------------------------------------------
// frx_pkg
// Types, codes and constants of the framed packet receive ring.
// ----------------------------------------------------------------------------
package frx_pkg;

   localparam int RING_SIZE_DEF = 1024;
   localparam int FRAME_SIZE    = 1024;
   localparam int MAX_READ      = 64;
   localparam int HDR_LEN       = 4;

   localparam int ACT_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 7;
   localparam int LEN_W   = 16;
   localparam int AVAIL_W = 10;
   localparam int DROP_W  = 32;

   localparam logic [BYTE_W-1:0] SIG_MARK = 8'hFF;

   typedef enum logic [ACT_W-1:0] {
      ACT_FRAME = 2'd0,
      ACT_READ  = 2'd1,
      ACT_FLUSH = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_VERDICT    = 2'd0,
      KIND_READ_BYTE  = 2'd1,
      KIND_READ_EMPTY = 2'd2,
      KIND_FLUSH      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_OK       = 3'd0,
      VERDICT_BAD_SIG  = 3'd1,
      VERDICT_BAD_LEN  = 3'd2,
      VERDICT_NO_SPACE = 3'd3,
      VERDICT_TRUNC    = 3'd4
   } verdict_type;

   // Frame parser state; the last three ignore bytes up to the frame end.
   typedef enum logic [2:0] {
      FS_HDR0     = 3'd0,
      FS_LEN_LO   = 3'd1,
      FS_LEN_HI   = 3'd2,
      FS_HDR3     = 3'd3,
      FS_PAYLOAD  = 3'd4,
      FS_BAD_SIG  = 3'd5,
      FS_BAD_LEN  = 3'd6,
      FS_NO_SPACE = 3'd7
   } frame_state_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } ctl_state_type;

   typedef struct packed {
      kind_type              kind;
      verdict_type           verdict;
      logic [BYTE_W-1:0]     data_byte;
      logic                  last;
      logic [AVAIL_W-1:0]    bytes_available;
      logic [DROP_W-1:0]     drop_count;
      logic                  blocked_flag;
   } rsp_item_type;

endpackage

/* rtl/core/frx_req_if.sv */
// ----------------------------------------------------------------------------
// frx_req_if
// Request channel: frame bytes, read requests and flush commands.
// ----------------------------------------------------------------------------
interface frx_req_if import frx_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] frame_byte;
   logic              frame_end;
   logic [CNT_W-1:0]  read_count;

   modport source (
      output valid, action, frame_byte, frame_end, read_count,
      input  ready
   );

   modport sink (
      input  valid, action, frame_byte, frame_end, read_count,
      output ready
   );

endinterface

/* rtl/core/frx_rsp_if.sv */
// ----------------------------------------------------------------------------
// frx_rsp_if
// Response channel: verdicts, popped bytes and command completions.
// ----------------------------------------------------------------------------
interface frx_rsp_if import frx_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         verdict;
   logic [BYTE_W-1:0]  data_byte;
   logic               last;
   logic [AVAIL_W-1:0] bytes_available;
   logic [DROP_W-1:0]  drop_count;
   logic               blocked_flag;

   modport source (
      output valid, kind, verdict, data_byte, last, bytes_available, drop_count,
             blocked_flag,
      input  ready
   );

   modport sink (
      input  valid, kind, verdict, data_byte, last, bytes_available, drop_count,
             blocked_flag,
      output ready
   );

endinterface

/* rtl/core/frx_ring_mem.sv */
// ----------------------------------------------------------------------------
// frx_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frx_ring_mem import frx_pkg::*; #(
   parameter int DEPTH = RING_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [BYTE_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [BYTE_W-1:0]          rd_data
);

   logic [BYTE_W-1:0] ring_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/frx_out_reg.sv */
// ----------------------------------------------------------------------------
// frx_out_reg
// Response output register; decouples result production from the sink.
// ----------------------------------------------------------------------------
module frx_out_reg import frx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         ready,
   output logic         valid,
   output rsp_item_type item,
   output logic         free
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Free when empty or when the held item transfers this cycle.
   assign free = !valid_ff || ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

/* rtl/core/framed_packet_rx_ring.sv */
// ----------------------------------------------------------------------------
// framed_packet_rx_ring
// Length-framed link receiver that stages payload into a byte ring.
// ----------------------------------------------------------------------------
// Each request transfer is a frame byte, a read request or a flush. A frame
// byte, a flush or an empty read completes at its transfer; a frame byte
// gives a result only when it carries frame_end. A read of n bytes (n =
// request clamped to 1..64 and to the bytes held) enters the read state,
// then fetches each byte into the memory read data register and moves it
// into the output register, one byte per cycle while that register is free,
// set by the single read port of the ring memory. No new request is taken
// until the last byte has moved into the output register. The ring memory
// needs no clearing pass after reset: only committed bytes are ever read.

`include "assert_macros.svh"

module framed_packet_rx_ring import frx_pkg::*; #(
   parameter int RING_SIZE = RING_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   frx_req_if.sink      req_ch,
   frx_rsp_if.source    rsp_ch
);

   localparam int IDX_W   = $clog2(RING_SIZE);
   localparam int HW      = IDX_W + 1;
   localparam int LW      = LEN_W + 1;
   localparam int MAX_LEN = ((RING_SIZE < FRAME_SIZE) ? RING_SIZE : FRAME_SIZE) - HDR_LEN;
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RING_SIZE - 1);
   localparam logic [HW-1:0]    RING_HW    = HW'(RING_SIZE);
   localparam logic [LW-1:0]    RING_LW    = LW'(RING_SIZE);
   localparam logic [LW-1:0]    MAX_LEN_LW = LW'(MAX_LEN);
   localparam logic [CNT_W-1:0] MAX_RD     = CNT_W'(MAX_READ);

   // bytes held between tail and head, modulo ring size
   function automatic logic [IDX_W-1:0] ring_held(input logic [IDX_W-1:0] h,
                                                  input logic [IDX_W-1:0] t);
      logic [HW-1:0] d;
      d = {1'b0, h} - {1'b0, t};
      if (h < t) begin
         d = d + RING_HW;
      end
      return d[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   // control and pointer state
   ctl_state_type     st_ff, st_in;
   frame_state_type   fs_ff, fs_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;   // staging pointer, head + pos
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;   // next byte to fetch in a read
   logic [CNT_W-1:0]  remain_ff, remain_in;   // bytes still to fetch
   logic              q_valid_ff, q_valid_in; // memory read data pending
   logic              q_last_ff, q_last_in;
   logic              blocked_ff, blocked_in;
   logic [DROP_W-1:0] dropped_ff, dropped_in;

   logic              req_ready;
   logic              req_fire;
   logic              issue;
   logic              q_take;
   logic              out_free;
   logic              out_load;
   rsp_item_type      out_item;
   rsp_item_type      rsp_item;
   logic              mem_wr_en;
   logic [BYTE_W-1:0] mem_rd_data;
   logic [IDX_W-1:0]  held_now;
   action_type        req_action;

   assign req_action = action_type'(req_ch.action);
   assign req_fire   = req_ch.valid && req_ready;
   assign held_now   = ring_held(head_ff, tail_ff);
   // fetched byte moves into the output register
   assign q_take     = q_valid_ff && out_free;

   // ---------------------------------------------------------------------
   // Control FSM: next state
   // ---------------------------------------------------------------------
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire && req_action == ACT_READ && held_now != '0) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            if (remain_ff == '0 && (!q_valid_ff || q_take)) begin
               st_in = ST_IDLE;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control FSM: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_ready = out_free;
         end
         ST_READ: begin
            // the read data register doubles as a skid slot
            issue = (remain_ff != '0) && (!q_valid_ff || q_take);
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath: frame parsing, commit, read setup and response build
   // ---------------------------------------------------------------------
   always_comb begin
      logic [CNT_W-1:0]  cnt;
      logic [CNT_W-1:0]  n;
      logic [HW-1:0]     tail_sum;
      logic [LW-1:0]     space_left;
      frame_state_type   fs_mid;
      logic [LEN_W-1:0]  len_mid;
      logic [LEN_W-1:0]  pos_mid;
      logic [IDX_W-1:0]  wr_mid;

      fs_in      = fs_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      remain_in  = remain_ff;
      q_valid_in = q_valid_ff;
      q_last_in  = q_last_ff;
      blocked_in = blocked_ff;
      dropped_in = dropped_ff;
      mem_wr_en  = 1'b0;
      out_load   = 1'b0;

      out_item.kind            = KIND_VERDICT;
      out_item.verdict         = VERDICT_OK;
      out_item.data_byte       = '0;
      out_item.last            = 1'b1;
      out_item.bytes_available = AVAIL_W'(held_now);
      out_item.drop_count      = dropped_ff;
      out_item.blocked_flag    = blocked_ff;

      cnt        = '0;
      n          = '0;
      tail_sum   = '0;
      space_left = RING_LW - LW'(held_now);
      fs_mid     = fs_ff;
      len_mid    = len_ff;
      pos_mid    = pos_ff;
      wr_mid     = wr_ptr_ff;

      if (req_fire) begin
         unique case (req_action)
            ACT_FRAME: begin
               unique case (fs_ff)
                  FS_HDR0: begin
                     fs_mid = (req_ch.frame_byte == SIG_MARK) ? FS_LEN_LO : FS_BAD_SIG;
                  end
                  FS_LEN_LO: begin
                     len_mid = LEN_W'(req_ch.frame_byte);
                     fs_mid  = FS_LEN_HI;
                  end
                  FS_LEN_HI: begin
                     len_mid = {req_ch.frame_byte, len_ff[BYTE_W-1:0]};
                     fs_mid  = FS_HDR3;
                  end
                  FS_HDR3: begin
                     // signature wins over length, length over space
                     if (req_ch.frame_byte != SIG_MARK) begin
                        fs_mid = FS_BAD_SIG;
                     end else if (len_ff == '0 || LW'(len_ff) > MAX_LEN_LW) begin
                        fs_mid = FS_BAD_LEN;
                     end else if (LW'(len_ff) >= space_left) begin
                        fs_mid = FS_NO_SPACE;
                     end else begin
                        fs_mid  = FS_PAYLOAD;
                        pos_mid = '0;
                        wr_mid  = head_ff;
                     end
                  end
                  FS_PAYLOAD: begin
                     // surplus bytes past the length are dropped
                     if (pos_ff < len_ff) begin
                        mem_wr_en = 1'b1;
                        pos_mid   = pos_ff + 1'b1;
                        wr_mid    = ptr_inc(wr_ptr_ff);
                     end
                  end
                  FS_BAD_SIG, FS_BAD_LEN, FS_NO_SPACE: begin
                  end
               endcase

               fs_in     = fs_mid;
               len_in    = len_mid;
               pos_in    = pos_mid;
               wr_ptr_in = wr_mid;

               if (req_ch.frame_end) begin
                  out_load = 1'b1;
                  if (fs_mid == FS_PAYLOAD && pos_mid == len_mid) begin
                     head_in          = wr_mid;
                     blocked_in       = 1'b0;
                     dropped_in       = '0;
                     out_item.verdict = VERDICT_OK;
                  end else if (fs_mid == FS_BAD_SIG) begin
                     out_item.verdict = VERDICT_BAD_SIG;
                  end else if (fs_mid == FS_BAD_LEN) begin
                     out_item.verdict = VERDICT_BAD_LEN;
                  end else if (fs_mid == FS_NO_SPACE) begin
                     if (dropped_ff != '1) begin
                        dropped_in = dropped_ff + 1'b1;
                     end
                     blocked_in       = 1'b1;
                     out_item.verdict = VERDICT_NO_SPACE;
                  end else begin
                     // frame cut short; staged bytes are simply abandoned
                     out_item.verdict = VERDICT_TRUNC;
                  end
                  fs_in  = FS_HDR0;
                  pos_in = '0;
                  len_in = '0;
                  out_item.bytes_available = AVAIL_W'(ring_held(head_in, tail_ff));
                  out_item.drop_count      = dropped_in;
                  out_item.blocked_flag    = blocked_in;
               end
            end
            ACT_READ: begin
               if (req_ch.read_count == '0) begin
                  cnt = CNT_W'(1);
               end else if (req_ch.read_count > MAX_RD) begin
                  cnt = MAX_RD;
               end else begin
                  cnt = req_ch.read_count;
               end
               if (held_now == '0) begin
                  out_load      = 1'b1;
                  out_item.kind = KIND_READ_EMPTY;
               end else begin
                  n = (LW'(cnt) < LW'(held_now)) ? cnt : CNT_W'(held_now);
                  // tail moves now; bytes_available of each byte is final
                  tail_sum = {1'b0, tail_ff} + HW'(n);
                  if (tail_sum >= RING_HW) begin
                     tail_sum = tail_sum - RING_HW;
                  end
                  tail_in   = tail_sum[IDX_W-1:0];
                  rd_ptr_in = tail_ff;
                  remain_in = n;
               end
            end
            ACT_FLUSH: begin
               tail_in                  = head_ff;
               out_load                 = 1'b1;
               out_item.kind            = KIND_FLUSH;
               out_item.bytes_available = '0;
            end
            default: begin
            end
         endcase
      end

      if (issue) begin
         rd_ptr_in  = ptr_inc(rd_ptr_ff);
         remain_in  = remain_ff - 1'b1;
         q_valid_in = 1'b1;
         q_last_in  = (remain_ff == CNT_W'(1));
      end else if (q_take) begin
         q_valid_in = 1'b0;
      end

      if (q_take) begin
         out_load           = 1'b1;
         out_item.kind      = KIND_READ_BYTE;
         out_item.data_byte = mem_rd_data;
         out_item.last      = q_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         fs_ff      <= FS_HDR0;
         len_ff     <= '0;
         pos_ff     <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         remain_ff  <= '0;
         q_valid_ff <= 1'b0;
         blocked_ff <= 1'b0;
         dropped_ff <= '0;
      end else begin
         st_ff      <= st_in;
         fs_ff      <= fs_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         remain_ff  <= remain_in;
         q_valid_ff <= q_valid_in;
         blocked_ff <= blocked_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      q_last_ff <= q_last_in;
   end

   // ---------------------------------------------------------------------
   // Ring memory. Staging writes happen only on request transfers in idle
   // and fetches only in the read state, so the ports never meet on one
   // entry in the same cycle.
   // ---------------------------------------------------------------------
   frx_ring_mem #(
      .DEPTH (RING_SIZE)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_ch.frame_byte),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   frx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_item (out_item),
      .ready     (rsp_ch.ready),
      .valid     (rsp_ch.valid),
      .item      (rsp_item),
      .free      (out_free)
   );

   assign req_ch.ready           = req_ready;
   assign rsp_ch.kind            = rsp_item.kind;
   assign rsp_ch.verdict         = rsp_item.verdict;
   assign rsp_ch.data_byte       = rsp_item.data_byte;
   assign rsp_ch.last            = rsp_item.last;
   assign rsp_ch.bytes_available = rsp_item.bytes_available;
   assign rsp_ch.drop_count      = rsp_item.drop_count;
   assign rsp_ch.blocked_flag    = rsp_item.blocked_flag;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `FRX_ASSERT_IMP(a_fetch_only_in_read, q_valid_ff, st_ff == ST_READ,
      "fetched byte pending outside the read state")
   `FRX_ASSERT(a_no_port_overlap, !(mem_wr_en && issue),
      "ring write and fetch in the same cycle")
   `FRX_ASSERT_IMP(a_idle_drained, st_ff == ST_IDLE, remain_ff == '0 && !q_valid_ff,
      "idle with read bytes still outstanding")
   `FRX_ASSERT(a_ptr_range, head_ff <= LAST_IDX && tail_ff <= LAST_IDX,
      "ring pointer beyond the ring size")

endmodule
